/* hw/rtl/ccbc_pkg.sv */
// ---------------------------------------------------------------------------
// ccbc_pkg
// Shared types and character codes for the comment blanker / bracket checker.
// ---------------------------------------------------------------------------
package ccbc_pkg;

  localparam int OUT_LINE_BITS = 20;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [1:0] KIND_PAREN = 2'd0;
  localparam logic [1:0] KIND_BRACK = 2'd1;
  localparam logic [1:0] KIND_BRACE = 2'd2;

  localparam logic [2:0] VERD_OK        = 3'd0;
  localparam logic [2:0] VERD_UNOPENED  = 3'd1;
  localparam logic [2:0] VERD_MISMATCH  = 3'd2;
  localparam logic [2:0] VERD_UNCLOSED  = 3'd3;
  localparam logic [2:0] VERD_OVERFLOW  = 3'd4;

  // One queue word: one or two scanned bytes from one input byte.
  typedef struct packed {
    logic       two;
    logic [7:0] c0;
    logic [7:0] c1;
    logic       last;
  } scan_word_t;

endpackage

/* hw/rtl/ccbc_ram.sv */
// ---------------------------------------------------------------------------
// ccbc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ccbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/ccbc_fifo.sv */
// ---------------------------------------------------------------------------
// ccbc_fifo
// Short register queue between the scanner and the bracket tracker.
// ---------------------------------------------------------------------------
module ccbc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = slot_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt  = do_push ? AW'((wptr_r + 1'b1) % DEPTH) : wptr_r;
    rptr_nxt  = do_pop  ? AW'((rptr_r + 1'b1) % DEPTH) : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= wr_data;
    end
  end

endmodule

/* hw/rtl/ccbc_scan.sv */
// ---------------------------------------------------------------------------
// ccbc_scan
// Front end: classifies source bytes, blanks comments and literals, and
// holds a lone slash one byte. Emits one queue word per producing byte.
// ---------------------------------------------------------------------------
module ccbc_scan #(
  parameter int LINE_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             in_char,
  input  logic                   in_last,
  input  logic                   in_push,
  output logic                   in_full,
  output logic                   q_push,
  output ccbc_pkg::scan_word_t   q_word,
  output logic [LINE_BITS-1:0]   q_line,
  input  logic                   q_full
);

  localparam logic [2:0] M_NORMAL     = 3'd0;
  localparam logic [2:0] M_LINE       = 3'd1;
  localparam logic [2:0] M_BLOCK      = 3'd2;
  localparam logic [2:0] M_BLOCK_STAR = 3'd3;
  localparam logic [2:0] M_QUOTE      = 3'd4;
  localparam logic [2:0] M_QUOTE_ESC  = 3'd5;

  logic [2:0]           mode_r, mode_nxt;
  logic                 slash_r, slash_nxt;
  logic                 single_r, single_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;

  logic       accept;
  logic       is_nl, is_quote, nb_hold;
  logic [7:0] nb_char, quote_ch, keep_nl;
  logic [1:0] n;
  logic [7:0] c0, c1;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  always_comb begin
    is_nl    = (in_char == ccbc_pkg::CH_NL);
    is_quote = (in_char == ccbc_pkg::CH_DQUOTE) || (in_char == ccbc_pkg::CH_SQUOTE);
    nb_hold  = (in_char == ccbc_pkg::CH_SLASH) && !in_last;
    nb_char  = is_quote ? ccbc_pkg::CH_SPACE : in_char;
    keep_nl  = is_nl ? ccbc_pkg::CH_NL : ccbc_pkg::CH_SPACE;
    quote_ch = single_r ? ccbc_pkg::CH_SQUOTE : ccbc_pkg::CH_DQUOTE;

    mode_nxt   = mode_r;
    slash_nxt  = slash_r;
    single_nxt = single_r;
    n          = 2'd0;
    c0         = ccbc_pkg::CH_SPACE;
    c1         = ccbc_pkg::CH_SPACE;

    case (mode_r)
      M_NORMAL: begin
        if (slash_r && in_char == ccbc_pkg::CH_SLASH) begin
          slash_nxt = 1'b0;
          mode_nxt  = M_LINE;
          n         = 2'd2;
        end else if (slash_r && in_char == ccbc_pkg::CH_STAR) begin
          slash_nxt = 1'b0;
          mode_nxt  = M_BLOCK;
          n         = 2'd2;
        end else begin
          slash_nxt = nb_hold;
          if (is_quote) begin
            mode_nxt   = M_QUOTE;
            single_nxt = (in_char == ccbc_pkg::CH_SQUOTE);
          end
          if (slash_r) begin
            c0 = ccbc_pkg::CH_SLASH;
            c1 = nb_char;
            n  = nb_hold ? 2'd1 : 2'd2;
          end else begin
            c0 = nb_char;
            n  = nb_hold ? 2'd0 : 2'd1;
          end
        end
      end
      M_LINE: begin
        n  = 2'd1;
        c0 = keep_nl;
        if (is_nl) begin
          mode_nxt = M_NORMAL;
        end
      end
      M_BLOCK, M_BLOCK_STAR: begin
        n  = 2'd1;
        c0 = keep_nl;
        if (is_nl) begin
          mode_nxt = M_BLOCK;
        end else if (mode_r == M_BLOCK_STAR && in_char == ccbc_pkg::CH_SLASH) begin
          mode_nxt = M_NORMAL;
        end else begin
          mode_nxt = (in_char == ccbc_pkg::CH_STAR) ? M_BLOCK_STAR : M_BLOCK;
        end
      end
      M_QUOTE: begin
        n  = 2'd1;
        c0 = keep_nl;
        if (in_char == quote_ch) begin
          mode_nxt = M_NORMAL;
        end else if (in_char == ccbc_pkg::CH_BSLASH) begin
          mode_nxt = M_QUOTE_ESC;
        end
      end
      default: begin
        n        = 2'd1;
        c0       = keep_nl;
        mode_nxt = M_QUOTE;
      end
    endcase

    if (in_last && n == 2'd0) begin
      n  = 2'd1;
      c0 = ccbc_pkg::CH_SPACE;
    end

    line_nxt = (is_nl && line_r != '1) ? line_r + 1'b1 : line_r;
    if (in_last) begin
      mode_nxt   = M_NORMAL;
      slash_nxt  = 1'b0;
      single_nxt = 1'b0;
      line_nxt   = LINE_BITS'(1);
    end
  end

  assign q_push      = accept && (n != 2'd0);
  assign q_word.two  = (n == 2'd2);
  assign q_word.c0   = c0;
  assign q_word.c1   = c1;
  assign q_word.last = in_last;
  assign q_line      = line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_NORMAL;
      slash_r  <= 1'b0;
      single_r <= 1'b0;
      line_r   <= LINE_BITS'(1);
    end else if (accept) begin
      mode_r   <= mode_nxt;
      slash_r  <= slash_nxt;
      single_r <= single_nxt;
      line_r   <= line_nxt;
    end
  end

endmodule

/* hw/rtl/ccbc_track.sv */
// ---------------------------------------------------------------------------
// ccbc_track
// Back end: feeds scanned bytes out one per cycle while fed and popped, and
// checks bracket balance on a stack: top two in registers, the rest in RAM.
// ---------------------------------------------------------------------------
module ccbc_track #(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_BITS   = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  ccbc_pkg::scan_word_t                 q_word,
  input  logic [LINE_BITS-1:0]                 q_line,
  output logic                                 q_pop,
  output logic [7:0]                           out_char,
  output logic                                 out_last,
  output logic [2:0]                           verdict,
  output logic [ccbc_pkg::OUT_LINE_BITS-1:0]   error_line,
  output logic                                 out_empty,
  input  logic                                 out_pop
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int EW = 2 + LINE_BITS;
  localparam int XW = LINE_BITS + ccbc_pkg::OUT_LINE_BITS;

  logic                 sub_r, sub_nxt;
  logic [FW-1:0]        fill_r, fill_nxt, fill_a;
  logic [EW-1:0]        top_r, top_nxt;
  logic [EW-1:0]        under_r, under_nxt;
  logic [2:0]           err_r, err_nxt, err_a;
  logic [LINE_BITS-1:0] eln_r, eln_nxt, eln_a;

  logic                                out_valid_r;
  logic [7:0]                          char_r;
  logic                                last_r;
  logic [2:0]                          verd_r;
  logic [ccbc_pkg::OUT_LINE_BITS-1:0]  eline_r;

  logic                 advance, blast, is_open, is_close, do_push, do_pop;
  logic [7:0]           cur;
  logic [1:0]           kind;
  logic [2:0]           v;
  logic [LINE_BITS-1:0] ln;
  logic [XW-1:0]        ln_ext;
  logic [EW-1:0]        rd_data;
  logic [FW-1:0]        rd_idx;

  assign advance = q_valid && (!out_valid_r || out_pop);
  assign cur     = sub_r ? q_word.c1 : q_word.c0;
  assign blast   = q_word.last && (sub_r || !q_word.two);
  assign q_pop   = advance && (sub_r || !q_word.two);

  always_comb begin
    is_open  = 1'b0;
    is_close = 1'b0;
    kind     = ccbc_pkg::KIND_PAREN;
    case (cur)
      ccbc_pkg::CH_LPAREN: begin is_open  = 1'b1; kind = ccbc_pkg::KIND_PAREN; end
      ccbc_pkg::CH_LBRACK: begin is_open  = 1'b1; kind = ccbc_pkg::KIND_BRACK; end
      ccbc_pkg::CH_LBRACE: begin is_open  = 1'b1; kind = ccbc_pkg::KIND_BRACE; end
      ccbc_pkg::CH_RPAREN: begin is_close = 1'b1; kind = ccbc_pkg::KIND_PAREN; end
      ccbc_pkg::CH_RBRACK: begin is_close = 1'b1; kind = ccbc_pkg::KIND_BRACK; end
      ccbc_pkg::CH_RBRACE: begin is_close = 1'b1; kind = ccbc_pkg::KIND_BRACE; end
      default: begin
        is_open  = 1'b0;
        is_close = 1'b0;
      end
    endcase

    do_push = 1'b0;
    do_pop  = 1'b0;
    err_a   = err_r;
    eln_a   = eln_r;
    if (err_r == ccbc_pkg::VERD_OK) begin
      if (is_open) begin
        if (fill_r == FW'(STACK_DEPTH)) begin
          err_a = ccbc_pkg::VERD_OVERFLOW;
          eln_a = q_line;
        end else begin
          do_push = 1'b1;
        end
      end else if (is_close) begin
        if (fill_r == '0) begin
          err_a = ccbc_pkg::VERD_UNOPENED;
          eln_a = q_line;
        end else if (top_r[EW-1 -: 2] != kind) begin
          err_a = ccbc_pkg::VERD_MISMATCH;
          eln_a = q_line;
        end else begin
          do_pop = 1'b1;
        end
      end
    end

    fill_a    = fill_r;
    top_nxt   = top_r;
    under_nxt = under_r;
    if (do_push) begin
      fill_a    = fill_r + 1'b1;
      top_nxt   = {kind, q_line};
      under_nxt = top_r;
    end else if (do_pop) begin
      fill_a    = fill_r - 1'b1;
      top_nxt   = under_r;
      under_nxt = rd_data;
    end

    v  = err_a;
    ln = eln_a;
    if (v == ccbc_pkg::VERD_OK && fill_a != '0) begin
      v  = ccbc_pkg::VERD_UNCLOSED;
      ln = top_nxt[LINE_BITS-1:0];
    end
    if (v == ccbc_pkg::VERD_OK) begin
      ln = '0;
    end
    ln_ext = {{ccbc_pkg::OUT_LINE_BITS{1'b0}}, ln};

    sub_nxt  = sub_r;
    fill_nxt = fill_r;
    err_nxt  = err_r;
    eln_nxt  = eln_r;
    if (advance) begin
      sub_nxt = q_word.two && !sub_r;
      if (blast) begin
        fill_nxt = '0;
        err_nxt  = ccbc_pkg::VERD_OK;
        eln_nxt  = '0;
      end else begin
        fill_nxt = fill_a;
        err_nxt  = err_a;
        eln_nxt  = eln_a;
      end
    end
    rd_idx = fill_nxt - FW'(3);
  end

  ccbc_ram #(
    .WIDTH (EW),
    .DEPTH (1 << AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (advance && do_push),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data ({kind, q_line}),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= 1'b0;
      fill_r      <= '0;
      err_r       <= ccbc_pkg::VERD_OK;
      eln_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sub_r  <= sub_nxt;
      fill_r <= fill_nxt;
      err_r  <= err_nxt;
      eln_r  <= eln_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      top_r   <= top_nxt;
      under_r <= under_nxt;
      char_r  <= cur;
      last_r  <= blast;
      verd_r  <= blast ? v : ccbc_pkg::VERD_OK;
      eline_r <= blast ? ln_ext[ccbc_pkg::OUT_LINE_BITS-1:0] : '0;
    end
  end

  assign out_char   = char_r;
  assign out_last   = last_r;
  assign verdict    = verd_r;
  assign error_line = eline_r;
  assign out_empty  = !out_valid_r;

endmodule

/* hw/rtl/comment_blank_bracket_check.sv */
// ---------------------------------------------------------------------------
// comment_blank_bracket_check
// Blanks comments and quoted literals in C-like text and checks brackets.
// ---------------------------------------------------------------------------
// Takes one source byte per clock while full is low and returns the text
// with comments and literals turned into spaces (newlines kept), one byte
// per clock on the result side while pop is high; a slash pair yields two
// result words for its second byte and a held slash none for its first. The
// final result word (out_last) carries the bracket verdict and its one-based
// line. A byte reaches the result ports through the queue and the output
// register; the second byte of a pair follows once the first is popped. The
// stack update per byte keeps the two top entries in registers and the rest
// in a RAM read ahead, so one byte per clock goes out while words wait and
// pop is high. The four-word scanner-to-checker queue absorbs double words.
// ---------------------------------------------------------------------------
module comment_blank_bracket_check #(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_BITS   = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [7:0]                         in_char,
  input  logic                               in_last,
  input  logic                               push,
  output logic                               full,
  output logic [7:0]                         out_char,
  output logic                               out_last,
  output logic [2:0]                         verdict,
  output logic [ccbc_pkg::OUT_LINE_BITS-1:0] error_line,
  output logic                               empty,
  input  logic                               pop
);

  localparam int SW = $bits(ccbc_pkg::scan_word_t);
  localparam int QW = SW + LINE_BITS;

  ccbc_pkg::scan_word_t  s_word, t_word;
  logic [LINE_BITS-1:0]  s_line, t_line;
  logic                  s_push, q_full, q_empty, q_pop;
  logic [QW-1:0]         q_rd;

  ccbc_scan #(
    .LINE_BITS (LINE_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_char (in_char),
    .in_last (in_last),
    .in_push (push),
    .in_full (full),
    .q_push  (s_push),
    .q_word  (s_word),
    .q_line  (s_line),
    .q_full  (q_full)
  );

  ccbc_fifo #(
    .WIDTH (QW),
    .DEPTH (ccbc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (s_push),
    .wr_data ({s_word, s_line}),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd)
  );

  assign t_word = q_rd[QW-1 -: SW];
  assign t_line = q_rd[LINE_BITS-1:0];

  ccbc_track #(
    .STACK_DEPTH (STACK_DEPTH),
    .LINE_BITS   (LINE_BITS)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (!q_empty),
    .q_word     (t_word),
    .q_line     (t_line),
    .q_pop      (q_pop),
    .out_char   (out_char),
    .out_last   (out_last),
    .verdict    (verdict),
    .error_line (error_line),
    .out_empty  (empty),
    .out_pop    (pop)
  );

endmodule

/* test/tb_comment_blank_bracket_check.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_comment_blank_bracket_check
// Self-checking bench for the comment blanker and bracket checker.
// ---------------------------------------------------------------------------
// Feeds short directed texts, a stack overflow, and then random texts that
// are mostly well-formed C-like code with comments, literals and nested
// brackets, plus broken and noisy ones. A scanner model in the bench
// predicts every result word, and each popped word is compared field by
// field in order. Both sides idle at random between words.
// ---------------------------------------------------------------------------
module tb_comment_blank_bracket_check;
  import ccbc_pkg::*;

  localparam int STACK_MAX   = 64;
  localparam int LINE_BITS   = 20;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int ITEM_COUNT  = 850;

  typedef enum logic [2:0] {
    SCAN_TEXT,
    SCAN_LINE_CMT,
    SCAN_BLOCK_CMT,
    SCAN_BLOCK_STAR,
    SCAN_QUOTE,
    SCAN_QUOTE_ESC
  } scan_mode_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         drain;
  } src_byte_t;

  typedef struct {
    logic [7:0]               ch;
    logic                     last;
    logic [2:0]               verd;
    logic [OUT_LINE_BITS-1:0] line;
  } out_word_t;

  logic                     clk      = 1'b0;
  logic                     rst_n    = 1'b0;
  logic [7:0]               in_char  = 8'h00;
  logic                     in_last  = 1'b0;
  logic                     push     = 1'b0;
  logic                     full;
  logic [7:0]               out_char;
  logic                     out_last;
  logic [2:0]               verdict;
  logic [OUT_LINE_BITS-1:0] error_line;
  logic                     empty;
  logic                     pop      = 1'b0;

  comment_blank_bracket_check DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_char    (in_char),
    .in_last    (in_last),
    .push       (push),
    .full       (full),
    .out_char   (out_char),
    .out_last   (out_last),
    .verdict    (verdict),
    .error_line (error_line),
    .empty      (empty),
    .pop        (pop)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  scan_mode_t           mode;
  bit                   slash_held;
  bit                   single_quote;
  logic [LINE_BITS-1:0] line_no;
  logic [1:0]           kind_stk [STACK_MAX];
  logic [LINE_BITS-1:0] line_stk [STACK_MAX];
  int                   depth;
  logic [2:0]           err_code;
  logic [LINE_BITS-1:0] err_line;

  out_word_t  step_words[$];
  out_word_t  scanned_words[$];
  src_byte_t  source_bytes[$];
  logic [7:0] text_buf[$];

  int bytes_queued = 0;
  int bytes_taken  = 0;
  int mismatches   = 0;
  int cycles       = 0;

  function automatic void clear_scanner();
    mode         = SCAN_TEXT;
    slash_held   = 1'b0;
    single_quote = 1'b0;
    line_no      = LINE_BITS'(1);
    depth        = 0;
    err_code     = VERD_OK;
    err_line     = '0;
  endfunction

  function automatic void emit(logic [7:0] c);
    out_word_t w;
    w.ch   = c;
    w.last = 1'b0;
    w.verd = VERD_OK;
    w.line = '0;
    step_words.insert(step_words.size(), w);
  endfunction

  function automatic void put_text(logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endfunction

  function automatic logic [7:0] letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic void flag_error(logic [2:0] code);
    if (err_code == VERD_OK) begin
      err_code = code;
      err_line = line_no;
    end
  endfunction

  function automatic void plain_byte(logic [7:0] c, logic last);
    logic [1:0] kind;
    if (c == CH_LPAREN || c == CH_RPAREN) kind = KIND_PAREN;
    else if (c == CH_LBRACK || c == CH_RBRACK) kind = KIND_BRACK;
    else kind = KIND_BRACE;
    if (c == CH_SLASH) begin
      if (last) emit(c);
      else slash_held = 1'b1;
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      mode         = SCAN_QUOTE;
      single_quote = (c == CH_SQUOTE);
      emit(CH_SPACE);
    end else begin
      if (err_code == VERD_OK) begin
        if (c == CH_LPAREN || c == CH_LBRACK || c == CH_LBRACE) begin
          if (depth >= STACK_MAX) flag_error(VERD_OVERFLOW);
          else begin
            kind_stk[depth] = kind;
            line_stk[depth] = line_no;
            depth++;
          end
        end else if (c == CH_RPAREN || c == CH_RBRACK || c == CH_RBRACE) begin
          if (depth == 0) flag_error(VERD_UNOPENED);
          else if (kind_stk[depth-1] != kind) flag_error(VERD_MISMATCH);
          else depth--;
        end
      end
      emit(c);
    end
  endfunction

  function automatic void scan_byte(logic [7:0] c, logic last);
    logic [2:0]           v;
    logic [LINE_BITS-1:0] ln;
    logic [7:0]           q;
    out_word_t            w;
    case (mode)
      SCAN_TEXT: begin
        if (slash_held) begin
          slash_held = 1'b0;
          if (c == CH_SLASH || c == CH_STAR) begin
            if (c == CH_SLASH) mode = SCAN_LINE_CMT;
            else mode = SCAN_BLOCK_CMT;
            emit(CH_SPACE);
            emit(CH_SPACE);
          end else begin
            emit(CH_SLASH);
            plain_byte(c, last);
          end
        end else plain_byte(c, last);
      end
      SCAN_LINE_CMT: begin
        if (c == CH_NL) mode = SCAN_TEXT;
        emit((c == CH_NL) ? CH_NL : CH_SPACE);
      end
      SCAN_BLOCK_CMT, SCAN_BLOCK_STAR: begin
        if (c == CH_NL) begin
          mode = SCAN_BLOCK_CMT;
          emit(CH_NL);
        end else begin
          if (mode == SCAN_BLOCK_STAR && c == CH_SLASH) mode = SCAN_TEXT;
          else if (c == CH_STAR) mode = SCAN_BLOCK_STAR;
          else mode = SCAN_BLOCK_CMT;
          emit(CH_SPACE);
        end
      end
      SCAN_QUOTE: begin
        q = single_quote ? CH_SQUOTE : CH_DQUOTE;
        if (c == q) mode = SCAN_TEXT;
        else if (c == CH_BSLASH) mode = SCAN_QUOTE_ESC;
        emit((c == CH_NL) ? CH_NL : CH_SPACE);
      end
      default: begin
        mode = SCAN_QUOTE;
        emit((c == CH_NL) ? CH_NL : CH_SPACE);
      end
    endcase
    if (c == CH_NL && line_no != '1) line_no++;
    if (last) begin
      v  = err_code;
      ln = err_line;
      if (v == VERD_OK && depth > 0) begin
        v  = VERD_UNCLOSED;
        ln = line_stk[depth-1];
      end
      if (v == VERD_OK) ln = '0;
      if (step_words.size() == 0) emit(CH_SPACE);
      w      = step_words[step_words.size() - 1];
      w.last = 1'b1;
      w.verd = v;
      w.line = ln;
      step_words[step_words.size() - 1] = w;
      clear_scanner();
    end
    while (step_words.size() > 0) begin
      w = step_words.pop_front();
      scanned_words.insert(scanned_words.size(), w);
    end
  endfunction

  function automatic logic [7:0] special_byte(int k);
    case (k)
      0:       return CH_SLASH;
      1:       return CH_STAR;
      2:       return CH_NL;
      3:       return CH_DQUOTE;
      4:       return CH_SQUOTE;
      5:       return CH_BSLASH;
      6:       return CH_LPAREN;
      7:       return CH_LBRACK;
      8:       return CH_LBRACE;
      9:       return CH_RPAREN;
      10:      return CH_RBRACK;
      11:      return CH_RBRACE;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0:       b = 8'($urandom_range(0, 255));
      1:       b = letter();
      default: b = special_byte($urandom_range(0, 12));
    endcase
    return b;
  endfunction

  // Append a run of C-like tokens; tidy closes every bracket left open.
  task automatic build_text(int tokens, bit tidy);
    logic [7:0] opens[$];
    logic [7:0] c;
    logic [7:0] q;
    int         k;
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0: put_text(CH_NL);
        1: begin
          put_text(CH_SLASH);
          put_text(CH_SLASH);
          repeat ($urandom_range(0, 6)) begin
            c = pick_byte();
            if (c != CH_NL) put_text(c);
          end
          put_text(CH_NL);
        end
        2: begin
          put_text(CH_SLASH);
          put_text(CH_STAR);
          repeat ($urandom_range(0, 6)) put_text(pick_byte());
          put_text(CH_STAR);
          put_text(CH_SLASH);
        end
        3: begin
          q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
          put_text(q);
          repeat ($urandom_range(0, 6)) begin
            c = pick_byte();
            if (c == CH_BSLASH) begin
              put_text(c);
              put_text(pick_byte());
            end else if (c != q) put_text(c);
          end
          put_text(q);
        end
        4, 5: begin
          k = $urandom_range(6, 8);
          put_text(special_byte(k));
          opens.push_front(special_byte(k + 3));
        end
        6, 7: begin
          if (opens.size() > 0) put_text(opens.pop_front());
          else put_text(letter());
        end
        8: begin
          put_text(CH_SLASH);
          put_text(letter());
        end
        default: begin
          repeat ($urandom_range(1, 3)) put_text(letter());
        end
      endcase
    end
    if (tidy) begin
      while (opens.size() > 0) put_text(opens.pop_front());
    end
  endtask

  task automatic send(logic [7:0] c, logic last, bit drain);
    src_byte_t b;
    while (source_bytes.size() >= 256) @(posedge clk);
    b.ch    = c;
    b.last  = last;
    b.drain = drain;
    source_bytes.insert(source_bytes.size(), b);
    bytes_queued++;
  endtask

  task automatic flush_text(bit drain);
    int n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) send(text_buf[i], i == n - 1, drain && i == 0);
    text_buf.delete();
  endtask

  task automatic settle();
    while (bytes_taken != bytes_queued || scanned_words.size() != 0) @(posedge clk);
  endtask

  int send_wait  = 0;
  int send_calm  = 0;
  bit send_quiet = 1'b0;

  always @(posedge clk) begin : drive
    src_byte_t nb;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        scan_byte(in_char, in_last);
        bytes_taken++;
        if (send_calm == 0) begin
          send_quiet = ($urandom_range(0, 3) == 0);
          send_calm  = $urandom_range(8, 64);
        end
        send_calm--;
        send_wait = send_quiet ? 0 : $urandom_range(0, 15);
      end
      if (!push || !full) begin
        if (send_wait > 0) begin
          send_wait--;
          push <= 1'b0;
        end else if (source_bytes.size() > 0 &&
                     !(source_bytes[0].drain && scanned_words.size() > 0)) begin
          nb = source_bytes.pop_front();
          in_char <= nb.ch;
          in_last <= nb.last;
          push    <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  int recv_wait  = 0;
  int recv_calm  = 0;
  bit recv_quiet = 1'b0;

  always @(posedge clk) begin : watch
    out_word_t w;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (scanned_words.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected word: char %h last %b verdict %0d line %0d",
                     out_char, out_last, verdict, error_line);
          mismatches++;
        end else begin
          w = scanned_words.pop_front();
          if (out_char !== w.ch || out_last !== w.last || verdict !== w.verd ||
              error_line !== w.line) begin
            if (mismatches < 10)
              $display("word mismatch: exp %h %b %0d %0d, got %h %b %0d %0d",
                       w.ch, w.last, w.verd, w.line,
                       out_char, out_last, verdict, error_line);
            mismatches++;
          end
        end
        if (recv_calm == 0) begin
          recv_quiet = ($urandom_range(0, 3) == 0);
          recv_calm  = $urandom_range(8, 64);
        end
        recv_calm--;
        recv_wait = recv_quiet ? 0 : $urandom_range(0, 15);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] closers[$];
    int         n;
    int         pick;
    int         spot;
    clear_scanner();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send(8'hFF, 1'b1, 1'b0);
    send(CH_SLASH, 1'b1, 1'b0);
    send(CH_SLASH, 1'b0, 1'b0);
    send(CH_RPAREN, 1'b1, 1'b0);
    send(CH_LPAREN, 1'b0, 1'b0);
    send(CH_RBRACK, 1'b0, 1'b0);
    send(CH_LBRACE, 1'b1, 1'b0);
    send(CH_LBRACE, 1'b0, 1'b0);
    send(CH_NL, 1'b0, 1'b0);
    send(CH_LBRACK, 1'b1, 1'b0);
    send(CH_SQUOTE, 1'b0, 1'b0);
    send(CH_BSLASH, 1'b1, 1'b0);
    send(CH_DQUOTE, 1'b0, 1'b0);
    send(CH_BSLASH, 1'b0, 1'b0);
    send(CH_NL, 1'b0, 1'b0);
    send(CH_DQUOTE, 1'b0, 1'b0);
    send(8'h00, 1'b1, 1'b0);
    // hold the sender until everything so far has come back
    send(CH_SLASH, 1'b0, 1'b1);
    send(CH_STAR, 1'b0, 1'b0);
    send(CH_STAR, 1'b0, 1'b0);
    send(CH_SLASH, 1'b0, 1'b0);
    send(CH_SLASH, 1'b0, 1'b0);
    send(CH_SLASH, 1'b0, 1'b0);
    send(CH_LPAREN, 1'b0, 1'b0);
    send(CH_NL, 1'b0, 1'b0);
    send(CH_SLASH, 1'b1, 1'b0);

    repeat (STACK_MAX) send(CH_LPAREN, 1'b0, 1'b0);
    send(CH_LBRACE, 1'b1, 1'b0);

    while (bytes_queued < ITEM_COUNT) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        build_text($urandom_range(1, 14), 1'b1);
      end else if (pick < 14) begin
        build_text($urandom_range(1, 14), 1'b0);
      end else if (pick < 16) begin
        build_text($urandom_range(2, 14), 1'b1);
        spot = $urandom_range(0, text_buf.size() - 1);
        text_buf[spot] = special_byte($urandom_range(0, 11));
      end else if (pick < 18) begin
        repeat ($urandom_range(1, 30)) put_text(pick_byte());
      end else if (pick == 18) begin
        n = $urandom_range(56, 70);
        repeat (n) begin
          pick = $urandom_range(6, 8);
          put_text(special_byte(pick));
          closers.push_front(special_byte(pick + 3));
        end
        repeat ($urandom_range(n - 8, n)) put_text(closers.pop_front());
        closers.delete();
      end else begin
        put_text(pick_byte());
      end
      if (text_buf.size() == 0) put_text(CH_SPACE);
      flush_text($urandom_range(0, 7) == 0);
    end

    settle();
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
